### sv/quadratic_segment_dp_hull_unit_assert.svh
// assertion macros for the hull unit, switched off by ASSERT_OFF
`ifndef QUADRATIC_SEGMENT_DP_HULL_UNIT_ASSERT_SVH
`define QUADRATIC_SEGMENT_DP_HULL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define QSDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every clock edge, reset included
`define QSDH_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSDH_ASSERT(lbl, prop, msg)
`define QSDH_ASSERT_NR(lbl, prop, msg)
`endif
`endif

### sv/qsdh_pkg.sv
// shared types and constants of the hull unit
package qsdh_pkg;

  localparam int MAX_ITEMS_DEF = 1048576;

  localparam int VAL_W   = 8;
  localparam int SUM_W   = 28;
  localparam int Y_W     = 64;
  localparam int QC_W    = 5;
  localparam int LC_W    = 25;
  localparam int CFG_W   = 25;
  localparam int CFG_IW  = 2;
  localparam int MUL_W   = 35;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DX_W    = SUM_W + 1;
  localparam int ACC_W   = 96;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_QUAD  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LIN   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CONST = 2'd2;

  // one hull point as held in memory
  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [Y_W-1:0]   y;
  } hull_pt_t;

endpackage

### sv/quadratic_segment_dp_hull_unit.sv
// top level: sequencer for the convex hull grouping optimiser
//
//  port group | dir | words
//  in_        | in  | value, last; one word per item
//  out_       | out | best_total, final_res; one word per input word
//  cfg_       | in  | quad, lin, const coefficients by index
//
// An item runs through the multiplies for a*s, a*s*s and b*s, a head check for each
// point tested at the head, the best term and new point, a tail check for each point
// tested at the tail, and the push, one step at a time on the shared multiplier.
// After reset the unit writes hull entry 0 in its init state, and again
// after each word marked last. A new word is taken in idle even while a result
// still waits in the output register; a result stalls only the next finish.
module quadratic_segment_dp_hull_unit #(
  parameter int MAX_ITEMS = qsdh_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [qsdh_pkg::VAL_W-1:0]        in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qsdh_pkg::Y_W-1:0]   out_best_total,
  output logic                              out_final_res,
  input  logic                              cfg_wr_en,
  input  logic [qsdh_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [qsdh_pkg::CFG_W-1:0]        cfg_wdata
);

  `include "quadratic_segment_dp_hull_unit_assert.svh"

  localparam int DEPTH = MAX_ITEMS + 1;
  localparam int AW    = $clog2(MAX_ITEMS + 1);
  localparam int IW    = $clog2(MAX_ITEMS + 2);
  localparam logic [IW-1:0] DEPTH_I = IW'(MAX_ITEMS + 1);

  localparam int SW = qsdh_pkg::SUM_W;
  localparam int YW = qsdh_pkg::Y_W;
  localparam int MW = qsdh_pkg::MUL_W;
  localparam int PW = qsdh_pkg::PROD_W;
  localparam int DW = qsdh_pkg::DX_W;
  localparam int CW = qsdh_pkg::ACC_W;

  // sequencer states
  localparam logic [4:0] ST_INIT  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_AS    = 5'd2;
  localparam logic [4:0] ST_ASS   = 5'd3;
  localparam logic [4:0] ST_BS    = 5'd4;
  localparam logic [4:0] ST_KSUM  = 5'd5;
  localparam logic [4:0] ST_HREAD = 5'd6;
  localparam logic [4:0] ST_HMUL  = 5'd7;
  localparam logic [4:0] ST_HCMP  = 5'd8;
  localparam logic [4:0] ST_BEST  = 5'd9;
  localparam logic [4:0] ST_NY    = 5'd10;
  localparam logic [4:0] ST_TREAD = 5'd11;
  localparam logic [4:0] ST_T1    = 5'd12;
  localparam logic [4:0] ST_T2    = 5'd13;
  localparam logic [4:0] ST_T3    = 5'd14;
  localparam logic [4:0] ST_T4    = 5'd15;
  localparam logic [4:0] ST_T5    = 5'd16;
  localparam logic [4:0] ST_PUSH  = 5'd17;
  localparam logic [4:0] ST_DONE  = 5'd18;

  // control registers
  logic [4:0]    state_r, state_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [IW-1:0] front_idx_r, front_idx_nxt;
  logic [IW-1:0] back_idx_r, back_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [qsdh_pkg::QC_W-1:0] quad_r;
  logic [qsdh_pkg::LC_W-1:0] lin_r;
  logic [qsdh_pkg::LC_W-1:0] const_r;

  // datapath registers
  logic          last_r, last_nxt;
  logic [33:0]   as_r, as_nxt;
  logic [YW-1:0] ass_r, ass_nxt;
  logic [YW-1:0] k_r, k_nxt;
  logic [YW-1:0] m_r, m_nxt;
  logic [SW-1:0] hx_r, hx_nxt;
  logic [YW-1:0] hy_r, hy_nxt;
  logic [YW-1:0] dy_r, dy_nxt;
  logic [YW-1:0] best_r, best_nxt;
  logic [YW-1:0] ny_r, ny_nxt;
  logic [YW-1:0] dn_r, dn_nxt;
  logic [DW-1:0] dxs_r, dxs_nxt;
  logic [DW-1:0] dx2_r, dx2_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] lhs_r, lhs_nxt;
  logic [YW-1:0] res_best_r, res_best_nxt;
  logic          res_last_r, res_last_nxt;

  // memory and multiplier hookup
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  qsdh_pkg::hull_pt_t  wr_data;
  logic [AW-1:0]       rd_addr_a;
  logic [AW-1:0]       rd_addr_b;
  qsdh_pkg::hull_pt_t  rd_data_a;
  qsdh_pkg::hull_pt_t  rd_data_b;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod_r;

  // helper values
  logic [MW-1:0] slope;
  logic          more_pts;
  logic [CW-1:0] prod_ext;
  logic [CW-1:0] rhs;
  logic [YW-1:0] dy2;
  logic [DW-1:0] hdx;
  logic [DW-1:0] tdxs;
  logic [DW-1:0] tdx2;
  logic [IW-1:0] back_m1;
  logic [IW-1:0] back_m2;
  logic [IW-1:0] front_p1;
  logic          in_acc;
  logic          out_free;

  qsdh_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  qsdh_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // handshake
  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_best_total = res_best_r;
  assign out_final_res  = res_last_r;
  assign out_free       = !out_valid_r || !out_stall;

  // shared terms
  assign slope    = {as_r, 1'b0};
  assign front_p1 = front_idx_r + IW'(1);
  assign back_m1  = back_idx_r - IW'(1);
  assign back_m2  = back_idx_r - IW'(2);
  assign more_pts = front_p1 < back_idx_r;
  assign prod_ext = {{(CW - PW){prod_r[PW-1]}}, prod_r};
  assign rhs      = acc_r + (prod_ext << 32);
  assign hdx      = {1'b0, rd_data_b.x} - {1'b0, rd_data_a.x};
  assign dy2      = rd_data_a.y - rd_data_b.y;
  assign tdxs     = {1'b0, sum_r} - {1'b0, rd_data_a.x};
  assign tdx2     = {1'b0, rd_data_a.x} - {1'b0, rd_data_b.x};

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    front_idx_nxt = front_idx_r;
    back_idx_nxt  = back_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    last_nxt      = last_r;
    as_nxt        = as_r;
    ass_nxt       = ass_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    hx_nxt        = hx_r;
    hy_nxt        = hy_r;
    dy_nxt        = dy_r;
    best_nxt      = best_r;
    ny_nxt        = ny_r;
    dn_nxt        = dn_r;
    dxs_nxt       = dxs_r;
    dx2_nxt       = dx2_r;
    acc_nxt       = acc_r;
    lhs_nxt       = lhs_r;
    res_best_nxt  = res_best_r;
    res_last_nxt  = res_last_r;
    wr_en         = 1'b0;
    wr_addr       = back_idx_r[AW-1:0];
    wr_data       = '{x: sum_r, y: ny_r};
    rd_addr_a     = front_idx_r[AW-1:0];
    rd_addr_b     = front_p1[AW-1:0];
    mul_a         = '0;
    mul_b         = '0;
    case (state_r)
      ST_INIT: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data       = '{x: '0, y: '0};
        sum_nxt       = '0;
        front_idx_nxt = '0;
        back_idx_nxt  = IW'(1);
        state_nxt     = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          sum_nxt   = sum_r + SW'(in_value);
          last_nxt  = in_last;
          state_nxt = ST_AS;
        end
      end
      // a*s
      ST_AS: begin
        mul_a     = MW'($signed(quad_r));
        mul_b     = MW'(sum_r);
        state_nxt = ST_ASS;
      end
      // a*s*s
      ST_ASS: begin
        as_nxt    = prod_r[33:0];
        mul_a     = prod_r[MW-1:0];
        mul_b     = MW'(sum_r);
        state_nxt = ST_BS;
      end
      // b*s
      ST_BS: begin
        ass_nxt   = prod_r[YW-1:0];
        mul_a     = MW'($signed(lin_r));
        mul_b     = MW'(sum_r);
        state_nxt = ST_KSUM;
      end
      // per item offsets for best and the new point
      ST_KSUM: begin
        k_nxt     = ass_r + prod_r[YW-1:0] + YW'($signed(const_r));
        m_nxt     = ass_r - prod_r[YW-1:0];
        state_nxt = ST_HREAD;
      end
      ST_HREAD: begin
        state_nxt = ST_HMUL;
      end
      // head point arrived: slope test or straight to the best term
      ST_HMUL: begin
        hx_nxt = rd_data_a.x;
        hy_nxt = rd_data_a.y;
        dy_nxt = rd_data_b.y - rd_data_a.y;
        if (more_pts) begin
          mul_a     = slope;
          mul_b     = MW'($signed(hdx));
          state_nxt = ST_HCMP;
        end else begin
          mul_a     = MW'(rd_data_a.x);
          mul_b     = slope;
          state_nxt = ST_BEST;
        end
      end
      ST_HCMP: begin
        if ($signed({{(PW - YW){dy_r[YW-1]}}, dy_r}) > prod_r) begin
          front_idx_nxt = front_p1;
          state_nxt     = ST_HREAD;
        end else begin
          mul_a     = MW'(hx_r);
          mul_b     = slope;
          state_nxt = ST_BEST;
        end
      end
      ST_BEST: begin
        best_nxt  = hy_r - prod_r[YW-1:0] + k_r;
        state_nxt = ST_NY;
      end
      ST_NY: begin
        ny_nxt    = best_r + m_r;
        state_nxt = ST_TREAD;
      end
      // tail convexity loop
      ST_TREAD: begin
        rd_addr_a = back_m1[AW-1:0];
        rd_addr_b = back_m2[AW-1:0];
        state_nxt = more_pts ? ST_T1 : ST_PUSH;
      end
      ST_T1: begin
        dn_nxt    = ny_r - rd_data_a.y;
        dy_nxt    = dy2;
        dxs_nxt   = tdxs;
        dx2_nxt   = tdx2;
        mul_a     = MW'(dy2[31:0]);
        mul_b     = MW'($signed(tdxs));
        state_nxt = ST_T2;
      end
      ST_T2: begin
        acc_nxt   = prod_ext;
        mul_a     = MW'($signed(dy_r[63:32]));
        mul_b     = MW'($signed(dxs_r));
        state_nxt = ST_T3;
      end
      ST_T3: begin
        lhs_nxt   = rhs;
        mul_a     = MW'(dn_r[31:0]);
        mul_b     = MW'($signed(dx2_r));
        state_nxt = ST_T4;
      end
      ST_T4: begin
        acc_nxt   = prod_ext;
        mul_a     = MW'($signed(dn_r[63:32]));
        mul_b     = MW'($signed(dx2_r));
        state_nxt = ST_T5;
      end
      ST_T5: begin
        if ($signed(lhs_r) < $signed(rhs)) begin
          back_idx_nxt = back_m1;
          state_nxt    = ST_TREAD;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      // append the new point, overwriting the tail when full
      ST_PUSH: begin
        wr_en = 1'b1;
        if (back_idx_r >= DEPTH_I) begin
          wr_addr = AW'(MAX_ITEMS);
        end else begin
          back_idx_nxt = back_idx_r + IW'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_best_nxt  = best_r;
          res_last_nxt  = last_r;
          state_nxt     = last_r ? ST_INIT : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sum_r       <= '0;
      front_idx_r <= '0;
      back_idx_r  <= IW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r  <= '1;
      lin_r   <= '0;
      const_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        qsdh_pkg::CFG_QUAD:  quad_r  <= cfg_wdata[qsdh_pkg::QC_W-1:0];
        qsdh_pkg::CFG_LIN:   lin_r   <= cfg_wdata[qsdh_pkg::LC_W-1:0];
        qsdh_pkg::CFG_CONST: const_r <= cfg_wdata[qsdh_pkg::LC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    as_r       <= as_nxt;
    ass_r      <= ass_nxt;
    k_r        <= k_nxt;
    m_r        <= m_nxt;
    hx_r       <= hx_nxt;
    hy_r       <= hy_nxt;
    dy_r       <= dy_nxt;
    best_r     <= best_nxt;
    ny_r       <= ny_nxt;
    dn_r       <= dn_nxt;
    dxs_r      <= dxs_nxt;
    dx2_r      <= dx2_nxt;
    acc_r      <= acc_nxt;
    lhs_r      <= lhs_nxt;
    res_best_r <= res_best_nxt;
    res_last_r <= res_last_nxt;
  end

  // checks
  `QSDH_ASSERT(a_front_below_back, front_idx_r < back_idx_r, "hull deque empty")
  `QSDH_ASSERT(a_back_in_range, back_idx_r <= DEPTH_I, "hull deque beyond depth")
  `QSDH_ASSERT(a_init_restores, state_r == ST_INIT |=> front_idx_r == '0 && back_idx_r == IW'(1) && sum_r == '0, "restart left stale state")
  `QSDH_ASSERT(a_result_loaded, state_r == ST_DONE && out_free |=> out_valid_r && (state_r == ST_IDLE || state_r == ST_INIT), "finished word not presented")
  `QSDH_ASSERT_NR(a_reset_quiet, !rst_n |=> !out_valid_r && state_r == ST_INIT, "reset left output valid")

endmodule

### sv/qsdh_mem.sv
// hull point memory: one write port, two registered read ports
module qsdh_mem #(
  parameter int DEPTH = qsdh_pkg::MAX_ITEMS_DEF + 1,
  parameter int AW    = $clog2(qsdh_pkg::MAX_ITEMS_DEF + 1)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  qsdh_pkg::hull_pt_t wr_data,
  input  logic [AW-1:0]      rd_addr_a,
  input  logic [AW-1:0]      rd_addr_b,
  output qsdh_pkg::hull_pt_t rd_data_a,
  output qsdh_pkg::hull_pt_t rd_data_b
);

  qsdh_pkg::hull_pt_t mem_q [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem_q[rd_addr_a];
    rd_data_b <= mem_q[rd_addr_b];
  end

endmodule

### sv/qsdh_mul.sv
// shared signed multiplier with registered product
module qsdh_mul (
  input  logic                                clk,
  input  logic signed [qsdh_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [qsdh_pkg::MUL_W-1:0]   mul_b,
  output logic signed [qsdh_pkg::PROD_W-1:0]  prod_r
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

### tb/sv/quadratic_segment_dp_hull_unit_tb.sv
// testbench for the convex hull grouping optimiser: random words checked against a predictor
`timescale 1ns / 1ps

module quadratic_segment_dp_hull_unit_tb;

  localparam int HULL_CAP  = 64;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic [qsdh_pkg::VAL_W-1:0] value;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic [qsdh_pkg::Y_W-1:0] total;
    logic                     fin;
  } score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [qsdh_pkg::VAL_W-1:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [qsdh_pkg::Y_W-1:0] out_best_total;
  logic out_final_res;
  logic cfg_wr_en = 1'b0;
  logic [qsdh_pkg::CFG_IW-1:0] cfg_index = qsdh_pkg::CFG_QUAD;
  logic [qsdh_pkg::CFG_W-1:0] cfg_wdata = '0;

  // predictor state
  logic signed [qsdh_pkg::Y_W-1:0] coef_a, coef_b, coef_c;
  logic [qsdh_pkg::SUM_W-1:0] run_sum;
  logic [qsdh_pkg::SUM_W-1:0] pt_x [HULL_CAP];
  logic [qsdh_pkg::Y_W-1:0]   pt_y [HULL_CAP];
  int head_idx, tail_idx;

  in_word_t pending_words [$];
  score_t   expected_scores [$];
  int errors = 0;
  int scores_seen = 0;
  int finals_seen = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  quadratic_segment_dp_hull_unit #(.MAX_ITEMS(HULL_CAP - 1)) u_top (.*);

  always #1 clk = ~clk;

  // sign of p*q - r*t, exact on 64-bit operands
  function automatic int cross_sign(logic [63:0] p, q, r, t);
    logic signed [127:0] lhs, rhs;
    lhs = $signed({{64{p[63]}}, p}) * $signed({{64{q[63]}}, q});
    rhs = $signed({{64{r[63]}}, r}) * $signed({{64{t[63]}}, t});
    return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
  endfunction

  function automatic void clear_hull();
    run_sum = '0;
    pt_x[0] = '0;
    pt_y[0] = '0;
    head_idx = 0;
    tail_idx = 1;
  endfunction

  // one step of the optimiser, returns the expected score word
  function automatic score_t predict_score(in_word_t w);
    logic [63:0] s, slope, best, ny, aa, dx;
    score_t r;
    run_sum = run_sum + qsdh_pkg::SUM_W'(w.value);
    s = 64'(run_sum);
    aa = coef_a;
    slope = 64'd2 * aa * s;
    while (head_idx + 1 < tail_idx) begin
      dx = 64'(pt_x[head_idx + 1]) - 64'(pt_x[head_idx]);
      if (cross_sign(pt_y[head_idx + 1] - pt_y[head_idx], 64'd1, slope, dx) > 0)
        head_idx++;
      else
        break;
    end
    best = pt_y[head_idx] - 64'(pt_x[head_idx]) * slope + aa * s * s
           + 64'(coef_b) * s + 64'(coef_c);
    ny = best + aa * s * s - 64'(coef_b) * s;
    while (head_idx + 1 < tail_idx) begin
      if (cross_sign(pt_y[tail_idx - 1] - pt_y[tail_idx - 2],
                     s - 64'(pt_x[tail_idx - 1]), ny - pt_y[tail_idx - 1],
                     64'(pt_x[tail_idx - 1]) - 64'(pt_x[tail_idx - 2])) < 0)
        tail_idx--;
      else
        break;
    end
    if (tail_idx >= HULL_CAP) begin
      pt_x[HULL_CAP - 1] = s[qsdh_pkg::SUM_W-1:0];
      pt_y[HULL_CAP - 1] = ny;
    end else begin
      pt_x[tail_idx] = s[qsdh_pkg::SUM_W-1:0];
      pt_y[tail_idx] = ny;
      tail_idx++;
    end
    r.total = best;
    r.fin = w.last;
    if (w.last) clear_hull();
    return r;
  endfunction

  // input driver: predict on acceptance, random gaps outside quiet stretch
  always @(posedge clk) begin
    in_word_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        w.value = in_value;
        w.last = in_last;
        expected_scores.push_back(predict_score(w));
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // payload held
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 11) - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words[0];
        in_valid <= 1'b1;
        in_value <= w.value;
        in_last <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    score_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected score word %0d", out_best_total);
          errors++;
        end else begin
          e = expected_scores.pop_front();
          scores_seen++;
          if (out_final_res) finals_seen++;
          if (out_best_total !== e.total) begin
            $error("best_total expected %0d actual %0d", $signed(e.total), out_best_total);
            errors++;
          end
          if (out_final_res !== e.fin) begin
            $error("final_res expected %0d actual %0d", e.fin, out_final_res);
            errors++;
          end
        end
      end
      if (hold_rx) out_stall <= 1'b1;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [qsdh_pkg::CFG_IW-1:0] idx, logic [qsdh_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      qsdh_pkg::CFG_QUAD: coef_a = 64'(signed'(val[qsdh_pkg::QC_W-1:0]));
      qsdh_pkg::CFG_LIN:  coef_b = 64'(signed'(val[qsdh_pkg::LC_W-1:0]));
      default:            coef_c = 64'(signed'(val[qsdh_pkg::LC_W-1:0]));
    endcase
  endtask

  task automatic settle();
    while (pending_words.size() > 0 || expected_scores.size() > 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic void queue_word(int v, bit l);
    in_word_t w;
    w.value = v[qsdh_pkg::VAL_W-1:0];
    w.last = l;
    pending_words.push_back(w);
  endfunction

  // random sequences of mostly small lengths, sometimes long runs
  task automatic queue_random(int n);
    int len;
    while (n > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (len > n) len = n;
      for (int k = 0; k < len; k++)
        queue_word(($urandom_range(0, 19) == 0) ? 255 * $urandom_range(0, 1)
                   : $urandom_range(1, 255), k == len - 1);
      n -= len;
    end
  endtask

  initial begin
    coef_a = -64'sd1;
    coef_b = 0;
    coef_c = 0;
    clear_hull();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed: field extremes, zero value, ends of sequence at reset coefficients
    queue_word(1, 0); queue_word(255, 0); queue_word(0, 0); queue_word(128, 1);
    queue_word(255, 1); queue_word(0, 1); queue_word(1, 0); queue_word(85, 0);
    queue_word(170, 0); queue_word(255, 0); queue_word(255, 1);
    settle();

    // directed: coefficient extremes
    write_reg(qsdh_pkg::CFG_QUAD, 25'h1FFFFF0);
    write_reg(qsdh_pkg::CFG_LIN, 25'h0FFFFFF);
    write_reg(qsdh_pkg::CFG_CONST, 25'h1000000);
    for (int k = 0; k < 6; k++) queue_word(k == 2 ? 0 : 255 - 40 * k, k == 5);
    settle();
    write_reg(qsdh_pkg::CFG_LIN, 25'h1000000);
    write_reg(qsdh_pkg::CFG_CONST, 25'h0FFFFFF);
    for (int k = 0; k < 6; k++) queue_word(1 + 50 * k, k == 5);
    settle();

    // random phases with varied coefficients; one long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(qsdh_pkg::CFG_QUAD, 25'($urandom_range(16, 31)) | 25'h1FFFFE0);
      write_reg(qsdh_pkg::CFG_LIN, ph == 0 ? 25'h0 : 25'($urandom));
      write_reg(qsdh_pkg::CFG_CONST, ph == 0 ? 25'h0 : 25'($urandom));
      if (ph == 5) quiet = 1'b1;
      if (ph == 2) begin
        hold_rx = 1'b1;
        queue_random(120);
        repeat (600) @(posedge clk);
        hold_rx = 1'b0;
        settle();
      end else begin
        queue_random(100);
        settle();
      end
    end

    // long sequence that wraps the hull store
    write_reg(qsdh_pkg::CFG_QUAD, 25'h1FFFFFF);
    write_reg(qsdh_pkg::CFG_LIN, 25'h0);
    write_reg(qsdh_pkg::CFG_CONST, 25'h0);
    for (int k = 0; k < 300; k++) queue_word($urandom_range(1, 3), k == 299);
    settle();

    $display("covered %0d scored words, %0d sequence ends, coefficients at both extremes",
             scores_seen, finals_seen);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
